// ===== rtl/stdet_pkg.sv =====
// Shared types and constants for the spectrum trace detector.
package stdet_pkg;

  localparam int IDX_W     = 10;
  localparam int TRACE_LEN = 1 << IDX_W;
  localparam int BIN_W     = 10;
  localparam int AMP_WIDTH = 16;
  localparam int CNT_W     = 10;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;

  // old * (N - 1) + new, signed
  localparam int PROD_W    = AMP_WIDTH + CNT_W + 1;
  localparam int ACC_W     = PROD_W + 1;
  localparam int MAG_W     = ACC_W - 1;
  localparam int DIV_CNT_W = $clog2(MAG_W + 1);

  // -199 dB in 1/64 dB steps
  localparam logic signed [AMP_WIDTH-1:0] SEED_LEVEL = AMP_WIDTH'(-199 * 64);

  localparam logic [CNT_W-1:0] AVG_MIN   = CNT_W'(2);
  localparam logic [CNT_W-1:0] AVG_MAX   = CNT_W'(1000);
  localparam logic [CNT_W-1:0] AVG_RESET = CNT_W'(10);

  localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MAXH   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MINH   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MINMAX = 3'd4;
  localparam logic [MODE_W-1:0] MODE_AVG    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE = 2'd2;

  typedef struct packed {
    logic [BIN_W-1:0]            bin_index;
    logic signed [AMP_WIDTH-1:0] new_min_value;
    logic signed [AMP_WIDTH-1:0] new_max_value;
    logic                        first_of_sweep;
    logic                        last_of_sweep;
  } in_item_t;

  typedef struct packed {
    logic [BIN_W-1:0]            bin_index_out;
    logic signed [AMP_WIDTH-1:0] min_value;
    logic signed [AMP_WIDTH-1:0] max_value;
    logic                        trace_active;
    logic                        last_out;
  } out_item_t;

  // divider start request from the top level to the divider
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

endpackage

// ===== rtl/spectrum_trace_detector_unit.sv =====
// Spectrum trace detector top level: per-bin min/max trace stores and mode update.
// Flow: an input transfer reads the stores; S_READ runs the mode step, S_WRITE
//   writes back and loads the output register once it is free; average mode runs
//   S_MUL and the bit-serial divider (S_DIV) in between; one item is in flight at a time.
// A new item is taken only after the previous one has been loaded into the output register.
// Reset (rst_n, synchronous, low): mode off, N = 10, updates on, trace empty,
//   seed flag clear; trace stores are not cleared and hold garbage until written.
module spectrum_trace_detector_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // input bins
  input  logic                                in_valid,
  output logic                                in_ready,
  input  stdet_pkg::in_item_t                 in_data,
  // results
  output logic                                out_valid,
  input  logic                                out_ready,
  output stdet_pkg::out_item_t                out_data,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stdet_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stdet_pkg::CFG_DAT_W-1:0]     cfg_data
);

  localparam int AW = stdet_pkg::AMP_WIDTH;
  localparam int IW = stdet_pkg::IDX_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_MUL   = 5'b00100,
    S_DIV   = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [stdet_pkg::MODE_W-1:0] mode_r;
  logic [stdet_pkg::CNT_W-1:0]  count_r;
  logic [stdet_pkg::CNT_W-1:0]  nm1_r;     // N - 1, kept ready for the multiply
  logic                         upd_en_r;
  logic                         empty_r;
  logic                         seed_r;

  // item in flight
  stdet_pkg::in_item_t          item_r;
  logic [IW-1:0]                idx_r;
  logic signed [AW-1:0]         res_lo_r, res_lo_nxt;
  logic signed [AW-1:0]         res_hi_r, res_hi_nxt;
  logic                         avg_go;
  logic                         seed_eff;

  // output register
  logic                         out_valid_r;
  stdet_pkg::out_item_t         out_r;

  // memories
  logic [AW-1:0]                rd_min, rd_max;
  logic                         in_xfer;
  logic                         st_we;
  logic                         out_load;

  // divider
  stdet_pkg::div_req_t          div_req;
  logic                         div_done;
  logic signed [AW-1:0]         q_lo, q_hi;
  logic signed [stdet_pkg::PROD_W-1:0] prod_lo, prod_hi;
  logic signed [stdet_pkg::ACC_W-1:0]  acc_lo, acc_hi;

  logic signed [AW-1:0]         nmin, nmax, old_lo, old_hi, base_lo, base_hi;
  logic [stdet_pkg::CNT_W-1:0]  cnt_sat;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Both trace stores share one address; read on the input transfer so the
  // stored pair is on hand in S_READ. One item at a time keeps the write of an
  // item ahead of the read of the next, so no forwarding is needed.
  stdet_ram #(.WIDTH(AW), .DEPTH(stdet_pkg::TRACE_LEN)) u_min_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (idx_r),
    .wdata (res_lo_r),
    .re    (in_xfer),
    .raddr (IW'(in_data.bin_index)),
    .rdata (rd_min)
  );

  stdet_ram #(.WIDTH(AW), .DEPTH(stdet_pkg::TRACE_LEN)) u_max_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (idx_r),
    .wdata (res_hi_r),
    .re    (in_xfer),
    .raddr (IW'(in_data.bin_index)),
    .rdata (rd_max)
  );

  // Mode step, evaluated while the read data is valid.
  always_comb begin
    nmin    = item_r.new_min_value;
    nmax    = item_r.new_max_value;
    old_lo  = rd_min;
    old_hi  = rd_max;
    // empty trace: copy first, then run the mode step on the copy
    base_lo = empty_r ? nmin : old_lo;
    base_hi = empty_r ? nmax : old_hi;
    // first bin of a sweep decides whether the average sweep seeds
    seed_eff = item_r.first_of_sweep ? (base_hi < stdet_pkg::SEED_LEVEL) : seed_r;
    avg_go   = 1'b0;
    res_lo_nxt = base_lo;
    res_hi_nxt = base_hi;
    case (mode_r)
      stdet_pkg::MODE_NORMAL: begin
        res_lo_nxt = nmin;
        res_hi_nxt = nmax;
      end
      stdet_pkg::MODE_MAXH: begin
        res_hi_nxt = (base_hi > nmax) ? base_hi : nmax;
        res_lo_nxt = res_hi_nxt;
      end
      stdet_pkg::MODE_MINH: begin
        res_lo_nxt = (base_lo < nmin) ? base_lo : nmin;
        res_hi_nxt = res_lo_nxt;
      end
      stdet_pkg::MODE_MINMAX: begin
        res_lo_nxt = (base_lo < nmin) ? base_lo : nmin;
        res_hi_nxt = (base_hi > nmax) ? base_hi : nmax;
      end
      stdet_pkg::MODE_AVG: begin
        if (seed_eff) begin
          res_lo_nxt = nmin;
          res_hi_nxt = nmax;
        end else begin
          avg_go = 1'b1;   // base kept, averaged in S_MUL / S_DIV
        end
      end
      default: begin
        // off and unused codes: stores keep the (possibly copied) base
      end
    endcase
    if (!upd_en_r) begin
      res_lo_nxt = old_lo;
      res_hi_nxt = old_hi;
      avg_go     = 1'b0;
    end
  end

  // Average: old * (N - 1) + new, then divide by N in the serial divider.
  assign prod_lo = res_lo_r * $signed({1'b0, nm1_r});
  assign prod_hi = res_hi_r * $signed({1'b0, nm1_r});
  assign acc_lo  = stdet_pkg::ACC_W'(prod_lo) + stdet_pkg::ACC_W'(nmin);
  assign acc_hi  = stdet_pkg::ACC_W'(prod_hi) + stdet_pkg::ACC_W'(nmax);

  assign div_req.start   = (state_r == S_MUL);
  assign div_req.divisor = count_r;

  stdet_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (div_req),
    .dividend_lo (acc_lo),
    .dividend_hi (acc_hi),
    .done        (div_done),
    .quot_lo     (q_lo),
    .quot_hi     (q_hi)
  );

  // Write-back and result load wait for a free output slot.
  assign out_load = (state_r == S_WRITE) && (!out_valid_r || out_ready);
  assign st_we    = out_load && upd_en_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_xfer) state_nxt = S_READ;
      S_READ:  state_nxt = avg_go ? S_MUL : S_WRITE;
      S_MUL:   state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_WRITE;
      S_WRITE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // saturate the averaging length into its legal range
  always_comb begin
    cnt_sat = cfg_data[stdet_pkg::CNT_W-1:0];
    if (cnt_sat < stdet_pkg::AVG_MIN) begin
      cnt_sat = stdet_pkg::AVG_MIN;
    end else if (cnt_sat > stdet_pkg::AVG_MAX) begin
      cnt_sat = stdet_pkg::AVG_MAX;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= stdet_pkg::MODE_OFF;
      count_r     <= stdet_pkg::AVG_RESET;
      nm1_r       <= stdet_pkg::AVG_RESET - stdet_pkg::CNT_W'(1);
      upd_en_r    <= 1'b1;
      empty_r     <= 1'b1;
      seed_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == S_READ && upd_en_r && item_r.first_of_sweep) begin
        seed_r <= seed_eff;
      end
      if (st_we && item_r.last_of_sweep) begin
        empty_r <= 1'b0;
      end

      // the user must send configuration writes only while idle; the block does not enforce it
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          stdet_pkg::REG_MODE: begin
            if (cfg_data[stdet_pkg::MODE_W-1:0] != mode_r) begin
              mode_r  <= cfg_data[stdet_pkg::MODE_W-1:0];
              empty_r <= 1'b1;
            end
          end
          stdet_pkg::REG_COUNT: begin
            count_r <= cnt_sat;
            nm1_r   <= cnt_sat - stdet_pkg::CNT_W'(1);
            empty_r <= 1'b1;
          end
          stdet_pkg::REG_UPDATE: begin
            upd_en_r <= cfg_data[0];
          end
          default: begin
            // unmapped index: ignored
          end
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_data;
      idx_r  <= IW'(in_data.bin_index);
    end
    if (state_r == S_READ) begin
      res_lo_r <= res_lo_nxt;
      res_hi_r <= res_hi_nxt;
    end else if (state_r == S_DIV && div_done) begin
      res_lo_r <= q_lo;
      res_hi_r <= q_hi;
    end
    if (out_load) begin
      out_r.bin_index_out <= stdet_pkg::BIN_W'(idx_r);
      out_r.min_value     <= res_lo_r;
      out_r.max_value     <= res_hi_r;
      out_r.trace_active  <= (mode_r != stdet_pkg::MODE_OFF);
      out_r.last_out      <= item_r.last_of_sweep;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/stdet_ram.sv =====
// Generic single-port-write, registered-read RAM.
module stdet_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/stdet_div.sv =====
// Two-lane restoring divider, one quotient bit per cycle, signed dividend.
module stdet_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  stdet_pkg::div_req_t                 req,
  input  logic signed [stdet_pkg::ACC_W-1:0]  dividend_lo,
  input  logic signed [stdet_pkg::ACC_W-1:0]  dividend_hi,
  output logic                                done,
  output logic signed [stdet_pkg::AMP_WIDTH-1:0] quot_lo,
  output logic signed [stdet_pkg::AMP_WIDTH-1:0] quot_hi
);

  localparam int MW = stdet_pkg::MAG_W;
  localparam int CW = stdet_pkg::CNT_W;

  logic [MW-1:0]                     mag_r [2];
  logic [MW-1:0]                     mag_nxt [2];
  logic [CW-1:0]                     rem_r [2];
  logic [CW-1:0]                     rem_nxt [2];
  logic                              neg_r [2];
  logic [CW-1:0]                     div_r;
  logic [stdet_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic                              run_r;
  logic                              done_r;
  logic signed [stdet_pkg::ACC_W-1:0] dvd [2];
  logic signed [stdet_pkg::ACC_W-1:0] absd [2];
  logic [MW-1:0]                     q_mag [2];

  assign dvd[0] = dividend_lo;
  assign dvd[1] = dividend_hi;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic [CW:0] trial;
      trial = {rem_r[l], mag_r[l][MW-1]};
      absd[l] = dvd[l][stdet_pkg::ACC_W-1] ? -dvd[l] : dvd[l];
      if (trial >= {1'b0, div_r}) begin
        rem_nxt[l] = CW'(trial - {1'b0, div_r});
        mag_nxt[l] = {mag_r[l][MW-2:0], 1'b1};
      end else begin
        rem_nxt[l] = trial[CW-1:0];
        mag_nxt[l] = {mag_r[l][MW-2:0], 1'b0};
      end
      q_mag[l] = neg_r[l] ? (~mag_r[l] + MW'(1)) : mag_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= stdet_pkg::DIV_CNT_W'(MW);
      end else if (run_r) begin
        cnt_r <= cnt_r - stdet_pkg::DIV_CNT_W'(1);
        if (cnt_r == stdet_pkg::DIV_CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      div_r <= req.divisor;
      for (int l = 0; l < 2; l++) begin
        mag_r[l] <= absd[l][MW-1:0];
        rem_r[l] <= '0;
        neg_r[l] <= dvd[l][stdet_pkg::ACC_W-1];
      end
    end else if (run_r) begin
      for (int l = 0; l < 2; l++) begin
        mag_r[l] <= mag_nxt[l];
        rem_r[l] <= rem_nxt[l];
      end
    end
  end

  assign done    = done_r;
  assign quot_lo = q_mag[0][stdet_pkg::AMP_WIDTH-1:0];
  assign quot_hi = q_mag[1][stdet_pkg::AMP_WIDTH-1:0];

endmodule

// ===== rtl/stdet_checker.sv =====
// Port-level checker for the spectrum trace detector, bound to the top level.
module stdet_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input stdet_pkg::out_item_t            out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item in flight: no input transfer right after another
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // a new result is only produced while the input side is closed
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an item in flight");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind spectrum_trace_detector_unit stdet_checker u_stdet_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the spectrum trace detector: directed script, random sweeps.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape
  localparam int TOTAL_BINS    = 1450;  // directed plus random input transfers
  localparam int SETTLE_CYCLES = 40;    // extra idle time before register writes and before the final verdict
  localparam int LONG_HOLD     = 300;   // receiver hold-off, long enough to back up the input

  // Codes the package leaves unnamed
  localparam logic [stdet_pkg::MODE_W-1:0]    MODE_RSVD6 = 3'd6;
  localparam logic [stdet_pkg::MODE_W-1:0]    MODE_RSVD7 = 3'd7;
  localparam logic [stdet_pkg::CFG_IDX_W-1:0] REG_RSVD   = 2'd3;

  typedef enum int {ROW_CFG, ROW_BIN} row_kind_t;
  typedef enum int {RX_OPEN, RX_BUSY, RX_SPARSE} rx_style_t;

  typedef struct packed {
    logic [stdet_pkg::CFG_IDX_W-1:0] sel;
    logic [stdet_pkg::CFG_DAT_W-1:0] val;
  } reg_wr_t;

  // One line of the directed script: a register write or a bin, with an
  // optional hand-written expectation for the bin.
  typedef struct {
    row_kind_t            kind;
    reg_wr_t              wr;
    stdet_pkg::in_item_t  bin;
    bit                   typed;
    stdet_pkg::out_item_t want;
  } script_row_t;

  // DUT connections, all inputs known from time zero
  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  stdet_pkg::in_item_t             in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  stdet_pkg::out_item_t            out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [stdet_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [stdet_pkg::CFG_DAT_W-1:0] cfg_data  = '0;

  // Trace predictor state: our own copy of the registers and the stores
  logic [stdet_pkg::MODE_W-1:0]           cur_mode    = stdet_pkg::MODE_OFF;
  int                                     avg_n       = stdet_pkg::AVG_RESET;
  bit                                     upd_on      = 1'b1;
  bit                                     empty_trace = 1'b1;
  bit                                     seed_on     = 1'b0;
  logic signed [stdet_pkg::AMP_WIDTH-1:0] lo_mem [stdet_pkg::TRACE_LEN];
  logic signed [stdet_pkg::AMP_WIDTH-1:0] hi_mem [stdet_pkg::TRACE_LEN];
  bit                                     seen_bin [stdet_pkg::TRACE_LEN];
  int                                     written_bins[$];   // bins that are safe to read back

  stdet_pkg::out_item_t pending_results[$];  // predicted stored pairs, oldest first
  script_row_t          script[$];
  reg_wr_t              reg_batch[$];        // register writes queued for the next idle window

  int err_cnt       = 0;
  int results_seen  = 0;
  int bins_sent     = 0;
  int reg_writes    = 0;
  int seeded_sweeps = 0;
  int frozen_bins   = 0;
  int burst_left    = 0;
  int rx_hold_req   = 0;  // set by the stimulus, consumed by the receiver

  spectrum_trace_detector_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Register write as the block sees it. A mode write only empties the trace
  // when the mode actually changes; any count write empties it.
  function automatic void reg_write(input logic [stdet_pkg::CFG_IDX_W-1:0] sel,
                                    input logic [stdet_pkg::CFG_DAT_W-1:0] val);
    case (sel)
      stdet_pkg::REG_MODE: begin
        if (val[stdet_pkg::MODE_W-1:0] != cur_mode) begin
          cur_mode    = val[stdet_pkg::MODE_W-1:0];
          empty_trace = 1'b1;
        end
      end
      stdet_pkg::REG_COUNT: begin
        if (val < stdet_pkg::AVG_MIN) begin
          avg_n = stdet_pkg::AVG_MIN;
        end else if (val > stdet_pkg::AVG_MAX) begin
          avg_n = stdet_pkg::AVG_MAX;
        end else begin
          avg_n = val;
        end
        empty_trace = 1'b1;
      end
      stdet_pkg::REG_UPDATE: upd_on = val[0];
      default: ;
    endcase
  endfunction

  // Stored pair after one bin goes through the trace update
  function automatic stdet_pkg::out_item_t trace_update(input stdet_pkg::in_item_t it);
    int unsigned          b;
    longint               lo, hi, nmin, nmax;
    stdet_pkg::out_item_t r;
    b    = it.bin_index;
    nmin = longint'($signed(it.new_min_value));
    nmax = longint'($signed(it.new_max_value));
    if (!upd_on) begin
      frozen_bins++;
    end else begin
      // an empty trace takes the new pair first, in every mode
      if (empty_trace) begin
        lo_mem[b] = it.new_min_value;
        hi_mem[b] = it.new_max_value;
      end
      if (it.first_of_sweep) begin
        seed_on = $signed(hi_mem[b]) < stdet_pkg::SEED_LEVEL;
        if (seed_on && cur_mode == stdet_pkg::MODE_AVG) seeded_sweeps++;
      end
      lo = lo_mem[b];
      hi = hi_mem[b];
      case (cur_mode)
        stdet_pkg::MODE_NORMAL: begin
          lo = nmin;
          hi = nmax;
        end
        stdet_pkg::MODE_MAXH: begin
          if (nmax > hi) hi = nmax;
          lo = hi;
        end
        stdet_pkg::MODE_MINH: begin
          if (nmin < lo) lo = nmin;
          hi = lo;
        end
        stdet_pkg::MODE_MINMAX: begin
          if (nmin < lo) lo = nmin;
          if (nmax > hi) hi = nmax;
        end
        stdet_pkg::MODE_AVG: begin
          if (seed_on) begin
            lo = nmin;
            hi = nmax;
          end else begin
            // integer division truncates toward zero, as the block does
            lo = (lo * (avg_n - 1) + nmin) / avg_n;
            hi = (hi * (avg_n - 1) + nmax) / avg_n;
          end
        end
        default: ;  // off and the reserved modes leave the stores alone
      endcase
      lo_mem[b] = stdet_pkg::AMP_WIDTH'(lo);
      hi_mem[b] = stdet_pkg::AMP_WIDTH'(hi);
      if (!seen_bin[b]) begin
        seen_bin[b] = 1'b1;
        written_bins = {written_bins, int'(b)};
      end
      if (it.last_of_sweep) empty_trace = 1'b0;
    end
    r.bin_index_out = it.bin_index;
    r.min_value     = lo_mem[b];
    r.max_value     = hi_mem[b];
    r.trace_active  = (cur_mode != stdet_pkg::MODE_OFF);
    r.last_out      = it.last_of_sweep;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // A bin may only be sent if the block will not read an entry it never
  // wrote: either the empty trace copies it in, or it was written before.
  function automatic logic [stdet_pkg::BIN_W-1:0] pick_bin(
      input logic [stdet_pkg::BIN_W-1:0] want);
    if ((upd_on && empty_trace) || seen_bin[want]) return want;
    return stdet_pkg::BIN_W'(written_bins[$urandom_range(written_bins.size() - 1, 0)]);
  endfunction

  // Amplitudes weighted toward the interesting spots: the seed threshold,
  // deep negatives that seed an average, and the rails.
  function automatic logic signed [stdet_pkg::AMP_WIDTH-1:0] rand_amp();
    logic signed [stdet_pkg::AMP_WIDTH-1:0] a;
    case ($urandom_range(7, 0))
      0, 1:    a = stdet_pkg::AMP_WIDTH'($urandom);
      2:       a = stdet_pkg::AMP_WIDTH'(int'(stdet_pkg::SEED_LEVEL) +
                                         int'($urandom_range(6, 0)) - 3);
      3, 4:    a = stdet_pkg::AMP_WIDTH'(-int'($urandom_range(32768, 12000)));
      5:       a = $urandom_range(1, 0) ? 16'sh7fff : 16'sh8000;
      default: a = stdet_pkg::AMP_WIDTH'(int'($urandom_range(4000, 0)) - 2000);
    endcase
    return a;
  endfunction

  // Offer one bin and hold it until the transfer; predict at the transfer.
  // Valid is only raised when low, so back-to-back bins keep it high.
  task automatic push_bin(input stdet_pkg::in_item_t it, input bit typed,
                          input stdet_pkg::out_item_t want);
    stdet_pkg::out_item_t calc;
    if (!in_valid) in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    calc = trace_update(it);
    if (typed) calc = want;
    pending_results = {pending_results, calc};
    bins_sent++;
  endtask

  // Sender in bursts: random burst lengths, random gaps, some bursts run on
  // straight into the next with no gap at all.
  task automatic offer_bin(input stdet_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push_bin(it, 1'b0, '0);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic settle_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Send the queued register writes while the block is idle. Valid stays up
  // across consecutive writes and drops after the last transfer.
  task automatic write_regs();
    settle_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    foreach (reg_batch[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_batch[i].sel;
      cfg_data  <= reg_batch[i].val;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      reg_write(reg_batch[i].sel, reg_batch[i].val);
      reg_writes++;
    end
    cfg_valid <= 1'b0;
    reg_batch.delete();
  endtask

  function automatic void cfg_row(input logic [stdet_pkg::CFG_IDX_W-1:0] sel,
                                  input int val);
    script_row_t r;
    r = '{kind: ROW_CFG, wr: '{sel: sel, val: stdet_pkg::CFG_DAT_W'(val)}, bin: '0,
          typed: 1'b0, want: '0};
    script = {script, r};
  endfunction

  function automatic void bin_row(input int idx, input int mn, input int mx,
                                  input bit f, input bit l);
    script_row_t r;
    r.kind                 = ROW_BIN;
    r.wr                   = '0;
    r.bin.bin_index        = stdet_pkg::BIN_W'(idx);
    r.bin.new_min_value    = stdet_pkg::AMP_WIDTH'(mn);
    r.bin.new_max_value    = stdet_pkg::AMP_WIDTH'(mx);
    r.bin.first_of_sweep   = f;
    r.bin.last_of_sweep    = l;
    r.typed                = 1'b0;
    r.want                 = '0;
    script = {script, r};
  endfunction

  // Bin with its stored pair written out by hand
  function automatic void bin_row_chk(input int idx, input int mn, input int mx,
                                      input bit f, input bit l,
                                      input int emn, input int emx, input bit act);
    bin_row(idx, mn, mx, f, l);
    script[$].typed              = 1'b1;
    script[$].want.bin_index_out = stdet_pkg::BIN_W'(idx);
    script[$].want.min_value     = stdet_pkg::AMP_WIDTH'(emn);
    script[$].want.max_value     = stdet_pkg::AMP_WIDTH'(emx);
    script[$].want.trace_active  = act;
    script[$].want.last_out      = l;
  endfunction

  // Directed script: every mode, the empty-trace copy, seeding, count
  // saturation at both ends, updates off, reserved modes and register.
  function automatic void build_script();
    // reset state: mode off, trace empty, so the copy still happens
    bin_row_chk(0, -32768, 32767, 1, 0, -32768, 32767, 0);
    bin_row_chk(1023, 32767, -32768, 0, 1, 32767, -32768, 0);
    bin_row_chk(0, 123, -456, 0, 0, -32768, 32767, 0);     // off, trace no longer empty
    cfg_row(stdet_pkg::REG_MODE, stdet_pkg::MODE_NORMAL);
    bin_row_chk(5, -100, 200, 1, 0, -100, 200, 1);
    bin_row_chk(1023, 0, 0, 0, 1, 0, 0, 1);
    cfg_row(stdet_pkg::REG_MODE, stdet_pkg::MODE_MAXH);
    bin_row_chk(5, 50, 300, 1, 0, 300, 300, 1);
    bin_row_chk(5, -5, 100, 0, 1, 100, 100, 1);            // still empty until this last
    bin_row_chk(5, 0, 400, 0, 0, 400, 400, 1);
    bin_row(5, 0, -32768, 0, 0);
    cfg_row(stdet_pkg::REG_MODE, stdet_pkg::MODE_MINH);
    bin_row_chk(0, -32768, 32767, 1, 1, -32768, -32768, 1);
    bin_row(0, 32767, 0, 0, 0);
    cfg_row(stdet_pkg::REG_MODE, stdet_pkg::MODE_MINMAX);
    bin_row_chk(7, -10, 10, 1, 1, -10, 10, 1);
    bin_row_chk(7, -20, 5, 0, 0, -20, 10, 1);
    bin_row(7, 0, 30, 0, 0);
    // N saturates up to 2, then averaging with a seeded first sweep
    cfg_row(stdet_pkg::REG_COUNT, 0);
    cfg_row(stdet_pkg::REG_MODE, stdet_pkg::MODE_AVG);
    bin_row_chk(7, -12800, -12800, 1, 0, -12800, -12800, 1);
    bin_row_chk(8, 1000, 1000, 0, 1, 1000, 1000, 1);
    bin_row(8, 0, 0, 1, 0);
    bin_row(7, -1, -1, 0, 0);                               // negative half truncates up
    // N saturates down to 1000
    cfg_row(stdet_pkg::REG_COUNT, 1023);
    bin_row_chk(8, 32767, -32768, 1, 1, 32767, -32768, 1);
    bin_row(8, -3, 7, 1, 0);
    bin_row(8, -1, 3, 1, 0);
    cfg_row(stdet_pkg::REG_UPDATE, 0);
    bin_row(8, 100, 100, 0, 1);                             // frozen trace
    cfg_row(stdet_pkg::REG_UPDATE, 1);
    cfg_row(stdet_pkg::REG_MODE, MODE_RSVD6);
    bin_row_chk(9, 11, 22, 1, 1, 11, 22, 1);
    cfg_row(stdet_pkg::REG_MODE, MODE_RSVD7);
    cfg_row(REG_RSVD, 1023);
    bin_row_chk(9, 1, 1, 0, 1, 1, 1, 1);
    cfg_row(stdet_pkg::REG_MODE, MODE_RSVD7);               // same mode: trace stays full
    bin_row_chk(9, 5, 5, 0, 0, 1, 1, 1);
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: stretches of a random style, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int        stretch;
    int        hold;
    rx_style_t style;
    stretch = 0;
    hold    = 0;
    style   = RX_OPEN;
    forever begin
      @(posedge clk);
      if (hold == 0 && rx_hold_req > 0) begin
        hold        = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        if (stretch == 0) begin
          stretch = $urandom_range(200, 20);
          style   = rx_style_t'($urandom_range(2, 0));
        end
        stretch--;
        case (style)
          RX_OPEN: out_ready <= 1'b1;
          RX_BUSY: out_ready <= ($urandom_range(9, 0) < 7);
          default: out_ready <= ($urandom_range(9, 0) < 2);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every result transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    stdet_pkg::out_item_t due;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result for bin %0d with nothing outstanding",
                                out_data.bin_index_out));
      end else begin
        due = pending_results.pop_front();
        if (out_data.bin_index_out !== due.bin_index_out)
          flag_mismatch($sformatf("bin_index_out got %0d want %0d",
                                  out_data.bin_index_out, due.bin_index_out));
        if (out_data.min_value !== due.min_value)
          flag_mismatch($sformatf("bin %0d min_value got %0d want %0d", due.bin_index_out,
                                  $signed(out_data.min_value), $signed(due.min_value)));
        if (out_data.max_value !== due.max_value)
          flag_mismatch($sformatf("bin %0d max_value got %0d want %0d", due.bin_index_out,
                                  $signed(out_data.max_value), $signed(due.max_value)));
        if (out_data.trace_active !== due.trace_active)
          flag_mismatch($sformatf("bin %0d trace_active got %b want %b", due.bin_index_out,
                                  out_data.trace_active, due.trace_active));
        if (out_data.last_out !== due.last_out)
          flag_mismatch($sformatf("bin %0d last_out got %b want %b", due.bin_index_out,
                                  out_data.last_out, due.last_out));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int                                     phase_no;
    int                                     span;
    int                                     base;
    int                                     nsweeps;
    int                                     r;
    int                                     cnt_picks[8];
    bit                                     first_f, last_f;
    logic [stdet_pkg::MODE_W-1:0]           m;
    logic [stdet_pkg::CFG_DAT_W-1:0]        v;
    logic signed [stdet_pkg::AMP_WIDTH-1:0] a, b, t;
    stdet_pkg::in_item_t                    it;

    cnt_picks = '{0, 1, 2, 3, 999, 1000, 1001, 1023};
    build_script();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: register rows are gathered and sent as one idle window
    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        reg_batch = {reg_batch, script[i].wr};
        if (i == script.size() - 1 || script[i + 1].kind != ROW_CFG) write_regs();
      end else begin
        push_bin(script[i].bin, script[i].typed, script[i].want);
      end
    end

    // Random part: phases of one register setting each, made of sweeps that
    // mostly revisit the same range so holds and averages build up over time
    phase_no = 0;
    while (bins_sent < TOTAL_BINS) begin
      phase_no++;
      if ($urandom_range(2, 0) != 0) begin
        r = $urandom_range(9, 0);
        m = (r > 7) ? stdet_pkg::MODE_AVG : stdet_pkg::MODE_W'(r);
        v = stdet_pkg::CFG_DAT_W'($urandom);
        v[stdet_pkg::MODE_W-1:0] = m;
        reg_batch = {reg_batch, reg_wr_t'{sel: stdet_pkg::REG_MODE, val: v}};
      end
      if ($urandom_range(2, 0) == 0) begin
        v = $urandom_range(1, 0) ? stdet_pkg::CFG_DAT_W'(cnt_picks[$urandom_range(7, 0)])
                                 : stdet_pkg::CFG_DAT_W'($urandom);
        reg_batch = {reg_batch, reg_wr_t'{sel: stdet_pkg::REG_COUNT, val: v}};
      end
      if ($urandom_range(3, 0) == 0 || !upd_on) begin
        v = stdet_pkg::CFG_DAT_W'($urandom);
        v[0] = ($urandom_range(3, 0) != 0);
        reg_batch = {reg_batch, reg_wr_t'{sel: stdet_pkg::REG_UPDATE, val: v}};
      end
      if (reg_batch.size() != 0) write_regs();

      span    = ($urandom_range(5, 0) == 0) ? $urandom_range(64, 25) : $urandom_range(16, 1);
      base    = $urandom_range(stdet_pkg::TRACE_LEN - 1, 0);
      nsweeps = $urandom_range(10, 2);

      // Once, starve the output long enough that the input backs up
      if (phase_no == 3) begin
        rx_hold_req = LONG_HOLD;
        if (span < 8) span = 8;
      end

      for (int s = 0; s < nsweeps && bins_sent < TOTAL_BINS; s++) begin
        // at random, the sender pauses until every outstanding result is back
        if ($urandom_range(9, 0) == 0) settle_results();
        if ($urandom_range(7, 0) == 0) base = $urandom_range(stdet_pkg::TRACE_LEN - 1, 0);
        for (int k = 0; k < span && bins_sent < TOTAL_BINS; k++) begin
          a = rand_amp();
          b = rand_amp();
          if ($urandom_range(2, 0) != 0 && b < a) begin
            t = a;
            a = b;
            b = t;
          end
          first_f = (k == 0);
          last_f  = (k == span - 1);
          // noise: flags that break the sweep framing
          if ($urandom_range(9, 0) == 0) begin
            first_f = $urandom_range(1, 0);
            last_f  = $urandom_range(1, 0);
          end
          it.bin_index      = pick_bin(stdet_pkg::BIN_W'(base + k));
          it.new_min_value  = a;
          it.new_max_value  = b;
          it.first_of_sweep = first_f;
          it.last_of_sweep  = last_f;
          offer_bin(it);
        end
      end
    end

    // Drain and let the block go quiet before judging
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d bins, %0d results checked, %0d register writes, %0d phases",
             bins_sent, results_seen, reg_writes, phase_no);
    $display("Seeded average sweeps %0d, bins with updates off %0d, bins touched %0d",
             seeded_sweeps, frozen_bins, written_bins.size());
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d results outstanding", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/stdet_pkg.sv
rtl/stdet_ram.sv
rtl/stdet_div.sv
rtl/spectrum_trace_detector_unit.sv
rtl/stdet_checker.sv
tb/sv/tb.sv
